@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset as disable.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

@@ design/whc_pkg.sv @@
package whc_pkg;

  localparam int WEIGHT_FRAC = 15;
  localparam int IN_W        = 224;
  localparam int OUT_W       = 208;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // magnitude + sign to signed 64, saturating
  function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input logic neg);
    logic [63:0] v;
    v = neg ? (~m[63:0] + 64'd1) : m[63:0];
    if (m[127:63] != 65'd0) begin
      v = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return $signed(v);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ design/whc_mul.sv @@
// 64x64 magnitude multiplier, one 32x32 partial product per cycle.
module whc_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic [127:0]       prod,
  output logic               neg,
  output logic               done
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [1:0]   cnt;
  logic         busy;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    opa = cnt[1] ? ma[63:32] : ma[31:0];
    opb = cnt[0] ? mb[63:32] : mb[31:0];
    pp  = opa * opb;
    case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= whc_pkg::mag64(a);
        mb   <= whc_pkg::mag64(b);
        neg  <= a[63] ^ b[63];
        prod <= 128'd0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + pp_sh;
        cnt  <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/whc_div.sv @@
// 128/128 restoring divider, one quotient bit per cycle.
module whc_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] n,
  input  logic [127:0] d,
  output logic [127:0] q,
  output logic         done
);

  logic [127:0] rem;
  logic [127:0] dr;
  logic [6:0]   cnt;
  logic         busy;
  logic [128:0] r2;
  logic [128:0] diff;
  logic         ge;

  always_comb begin
    r2   = {rem, q[127]};
    diff = r2 - {1'b0, dr};
    ge   = !diff[128];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= n;
        dr   <= d;
        rem  <= 128'd0;
        cnt  <= 7'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[127:0] : r2[127:0];
        q   <= {q[126:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/whc_sqrt.sv @@
// 64-bit integer square root, one result bit per cycle.
module whc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    trial = res + bitv;
    ge    = rem >= trial;
    root  = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= v;
        res  <= 64'd0;
        bitv <= {2'b01, 62'd0};
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/weighted_hit_combiner_2d_unit.sv @@
// Inverse-covariance weighted mean of a run of 2D hits, fixed point with
// FRAC_BITS fractional bits. Each non-outlier hit gets its 2x2 covariance
// inverted and folded, weight-scaled, into running sums; the hit with tlast
// closes the run, the summed weight matrix is inverted and one combined hit
// goes out. One item is taken at a time and s_tready stays low until its work
// (and any result) is done. Work goes through the shared units (the divider is
// bit-serial). A plain hit takes 2 multiplies, 2 more if its covariance is
// nonzero, then 9 more and 2 or 3 quotients; an outlier hit takes none. The
// closing hit of a run with no zero divisor adds one more inversion and, if
// that is not singular, 4 multiplies and 2 roots. A zero divisor anywhere in a
// run yields singular=1 with zero position, error and covariance fields.
module weighted_hit_combiner_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // hit_x, hit_y, hit_z, err_x, err_y, cov_xy, weight, plane_index, pad
  input  logic [whc_pkg::IN_W-1:0]    s_tdata,
  input  logic [0:0]                  s_tuser,   // is_outlier
  input  logic                        s_tlast,   // last_hit
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // eff_x, eff_y, eff_z, eff_err_x, eff_err_y, eff_cov_xy, eff_plane, pad
  output logic [whc_pkg::OUT_W-1:0]   m_tdata,
  output logic [0:0]                  m_tuser,   // singular
  output logic                        m_tvalid,
  input  logic                        m_tready
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_VXX  = 5'd1;
  localparam logic [4:0] ST_VYY  = 5'd2;
  localparam logic [4:0] ST_INV  = 5'd3;
  localparam logic [4:0] ST_PR   = 5'd4;
  localparam logic [4:0] ST_QQ   = 5'd5;
  localparam logic [4:0] ST_DA   = 5'd6;
  localparam logic [4:0] ST_DB   = 5'd7;
  localparam logic [4:0] ST_DC   = 5'd8;
  localparam logic [4:0] ST_INVD = 5'd9;
  localparam logic [4:0] ST_TX1  = 5'd10;
  localparam logic [4:0] ST_TX2  = 5'd11;
  localparam logic [4:0] ST_TY1  = 5'd12;
  localparam logic [4:0] ST_TY2  = 5'd13;
  localparam logic [4:0] ST_W1   = 5'd14;
  localparam logic [4:0] ST_W2   = 5'd15;
  localparam logic [4:0] ST_W3   = 5'd16;
  localparam logic [4:0] ST_W4   = 5'd17;
  localparam logic [4:0] ST_W5   = 5'd18;
  localparam logic [4:0] ST_CHK  = 5'd19;
  localparam logic [4:0] ST_RX1  = 5'd20;
  localparam logic [4:0] ST_RX2  = 5'd21;
  localparam logic [4:0] ST_RY1  = 5'd22;
  localparam logic [4:0] ST_RY2  = 5'd23;
  localparam logic [4:0] ST_SQX  = 5'd24;
  localparam logic [4:0] ST_SQY  = 5'd25;
  localparam logic [4:0] ST_OUT  = 5'd26;

  localparam logic signed [63:0] ERR_LIMIT = 64'sd1 <<< (62 - FRAC_BITS);

  logic [4:0] state;
  logic       issued;
  logic       in_group;
  logic       bad_flag;
  logic       fin_mode;   // inverting the summed matrix, not a hit
  logic       diag;       // off-diagonal zero: per-entry inversion
  logic       sing;
  logic       dneg;

  // latched hit
  logic signed [63:0] hx, hy, ex, ey, w;
  logic               last;

  // inversion operands / results and scratch
  logic signed [63:0] p, q, r, ga, gb, gc, tmp, tx, ty;
  logic [127:0]       pr, dm;

  // run sums
  logic signed [63:0] sum_g_xx, sum_g_xy, sum_g_yy, sum_m_x, sum_m_y;
  logic [31:0]        first_z;
  logic [15:0]        first_plane;

  // result
  logic [31:0] o_x, o_y, o_cov;
  logic [30:0] o_ex, o_ey;
  logic        o_sing;

  // shared units
  logic               mul_start, mul_neg, mul_done;
  logic signed [63:0] mul_a, mul_b;
  logic [127:0]       mul_prod;
  logic               div_start, div_done, div_neg;
  logic [127:0]       div_n, div_d, div_q;
  logic               sq_start, sq_done;
  logic [63:0]        sq_v;
  logic [31:0]        sq_root;

  logic signed [63:0] ms_f, ms_w, g_div, sq_src;
  logic [127:0]       dm_calc;
  logic               dneg_calc, pr_ge;
  logic [30:0]        err_val;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tuser  = o_sing;
  assign m_tdata  = {2'b00, first_plane, o_cov, o_ey, o_ex, first_z, o_y, o_x};

  // operand selection for the multiplier
  always_comb begin
    mul_a = 64'sd0;
    mul_b = 64'sd0;
    unique case (state)
      ST_VXX:  begin mul_a = ex; mul_b = ex; end
      ST_VYY:  begin mul_a = ey; mul_b = ey; end
      ST_PR:   begin mul_a = p;  mul_b = r;  end
      ST_QQ:   begin mul_a = q;  mul_b = q;  end
      ST_TX1:  begin mul_a = ga; mul_b = hx; end
      ST_TX2:  begin mul_a = gb; mul_b = hy; end
      ST_TY1:  begin mul_a = gc; mul_b = hy; end
      ST_TY2:  begin mul_a = gb; mul_b = hx; end
      ST_W1:   begin mul_a = w;  mul_b = ga; end
      ST_W2:   begin mul_a = w;  mul_b = gb; end
      ST_W3:   begin mul_a = w;  mul_b = gc; end
      ST_W4:   begin mul_a = w;  mul_b = tx; end
      ST_W5:   begin mul_a = w;  mul_b = ty; end
      ST_RX1:  begin mul_a = ga; mul_b = sum_m_x; end
      ST_RX2:  begin mul_a = gb; mul_b = sum_m_y; end
      ST_RY1:  begin mul_a = gc; mul_b = sum_m_y; end
      ST_RY2:  begin mul_a = gb; mul_b = sum_m_x; end
      default: begin mul_a = 64'sd0; mul_b = 64'sd0; end
    endcase
    mul_start = !issued && (state inside {ST_VXX, ST_VYY, ST_PR, ST_QQ, ST_TX1, ST_TX2,
        ST_TY1, ST_TY2, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_RX1, ST_RX2, ST_RY1, ST_RY2});
  end

  // divider operands: per-entry form is 2^2F / v, full form is m * 2^2F / det
  always_comb begin
    div_n   = 128'd0;
    div_d   = dm;
    div_neg = 1'b0;
    unique case (state)
      ST_DA: begin
        if (diag) begin
          div_n   = 128'd1 << (2 * FRAC_BITS);
          div_d   = {64'd0, whc_pkg::mag64(p)};
          div_neg = p[63];
        end else begin
          div_n   = {64'd0, whc_pkg::mag64(r)} << (2 * FRAC_BITS);
          div_neg = r[63] ^ dneg;
        end
      end
      ST_DB: begin
        div_n   = {64'd0, whc_pkg::mag64(q)} << (2 * FRAC_BITS);
        div_neg = q[63] ^ !dneg;
      end
      ST_DC: begin
        if (diag) begin
          div_n   = 128'd1 << (2 * FRAC_BITS);
          div_d   = {64'd0, whc_pkg::mag64(r)};
          div_neg = r[63];
        end else begin
          div_n   = {64'd0, whc_pkg::mag64(p)} << (2 * FRAC_BITS);
          div_neg = p[63] ^ dneg;
        end
      end
      default: begin
        div_n   = 128'd0;
        div_neg = 1'b0;
      end
    endcase
    div_start = !issued && (state == ST_DA || state == ST_DB || state == ST_DC);
  end

  always_comb begin
    ms_f  = whc_pkg::sat_mag(mul_prod >> FRAC_BITS, mul_neg);
    ms_w  = whc_pkg::sat_mag(mul_prod >> whc_pkg::WEIGHT_FRAC, mul_neg);
    g_div = whc_pkg::sat_mag(div_q, div_neg);

    // determinant p*r - q*q from magnitudes; mul_prod holds q*q in ST_QQ
    pr_ge     = pr >= mul_prod;
    dneg_calc = (p[63] ^ r[63]) || !pr_ge;
    if (p[63] ^ r[63]) begin
      dm_calc = pr + mul_prod;
    end else if (pr_ge) begin
      dm_calc = pr - mul_prod;
    end else begin
      dm_calc = mul_prod - pr;
    end

    sq_src   = (state == ST_SQY) ? gc : ga;
    sq_v     = sq_src << FRAC_BITS;
    sq_start = !issued && (state == ST_SQX || state == ST_SQY);
    if (sq_src <= 64'sd0) begin
      err_val = 31'd0;
    end else if (sq_src >= ERR_LIMIT || sq_root[31]) begin
      err_val = 31'h7FFF_FFFF;
    end else begin
      err_val = sq_root[30:0];
    end
  end

  whc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .neg   (mul_neg),
    .done  (mul_done)
  );

  whc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .q     (div_q),
    .done  (div_done)
  );

  whc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v     (sq_v),
    .root  (sq_root),
    .done  (sq_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      in_group    <= 1'b0;
      bad_flag    <= 1'b0;
      fin_mode    <= 1'b0;
      sum_g_xx    <= 64'sd0;
      sum_g_xy    <= 64'sd0;
      sum_g_yy    <= 64'sd0;
      sum_m_x     <= 64'sd0;
      sum_m_y     <= 64'sd0;
      first_z     <= 32'd0;
      first_plane <= 16'd0;
    end else begin
      if (mul_start || div_start || sq_start) begin
        issued <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            hx       <= {{32{s_tdata[31]}}, s_tdata[31:0]};
            hy       <= {{32{s_tdata[63]}}, s_tdata[63:32]};
            ex       <= {33'd0, s_tdata[126:96]};
            ey       <= {33'd0, s_tdata[157:127]};
            q        <= {{32{s_tdata[189]}}, s_tdata[189:158]};
            w        <= {48'd0, s_tdata[205:190]};
            last     <= s_tlast;
            fin_mode <= 1'b0;
            if (!in_group) begin
              first_z     <= s_tdata[95:64];
              first_plane <= s_tdata[221:206];
              in_group    <= 1'b1;
            end
            state <= s_tuser[0] ? ST_CHK : ST_VXX;
          end
        end
        ST_VXX: begin
          if (mul_done) begin
            issued <= 1'b0;
            p      <= ms_f;
            state  <= ST_VYY;
          end
        end
        ST_VYY: begin
          if (mul_done) begin
            issued <= 1'b0;
            r      <= ms_f;
            state  <= ST_INV;
          end
        end
        ST_INV: begin
          diag <= (q == 64'sd0);
          sing <= (q == 64'sd0) && (p == 64'sd0 || r == 64'sd0);
          if (q != 64'sd0) begin
            state <= ST_PR;
          end else if (p == 64'sd0 || r == 64'sd0) begin
            state <= ST_INVD;
          end else begin
            state <= ST_DA;
          end
        end
        ST_PR: begin
          if (mul_done) begin
            issued <= 1'b0;
            pr     <= mul_prod;
            state  <= ST_QQ;
          end
        end
        ST_QQ: begin
          if (mul_done) begin
            issued <= 1'b0;
            dm     <= dm_calc;
            dneg   <= dneg_calc;
            if (dm_calc == 128'd0) begin
              sing  <= 1'b1;
              state <= ST_INVD;
            end else begin
              state <= ST_DA;
            end
          end
        end
        ST_DA: begin
          if (div_done) begin
            issued <= 1'b0;
            ga     <= g_div;
            if (diag) begin
              gb    <= 64'sd0;
              state <= ST_DC;
            end else begin
              state <= ST_DB;
            end
          end
        end
        ST_DB: begin
          if (div_done) begin
            issued <= 1'b0;
            gb     <= g_div;
            state  <= ST_DC;
          end
        end
        ST_DC: begin
          if (div_done) begin
            issued <= 1'b0;
            gc     <= g_div;
            state  <= ST_INVD;
          end
        end
        ST_INVD: begin
          if (fin_mode) begin
            if (sing) begin
              o_x    <= 32'd0;
              o_y    <= 32'd0;
              o_ex   <= 31'd0;
              o_ey   <= 31'd0;
              o_cov  <= 32'd0;
              o_sing <= 1'b1;
              state  <= ST_OUT;
            end else begin
              state <= ST_RX1;
            end
          end else if (sing) begin
            bad_flag <= 1'b1;
            state    <= ST_CHK;
          end else begin
            state <= ST_TX1;
          end
        end
        ST_TX1: begin
          if (mul_done) begin
            issued <= 1'b0;
            tmp    <= ms_f;
            state  <= ST_TX2;
          end
        end
        ST_TX2: begin
          if (mul_done) begin
            issued <= 1'b0;
            tx     <= whc_pkg::sat_add(tmp, ms_f);
            state  <= ST_TY1;
          end
        end
        ST_TY1: begin
          if (mul_done) begin
            issued <= 1'b0;
            tmp    <= ms_f;
            state  <= ST_TY2;
          end
        end
        ST_TY2: begin
          if (mul_done) begin
            issued <= 1'b0;
            ty     <= whc_pkg::sat_add(tmp, ms_f);
            state  <= ST_W1;
          end
        end
        ST_W1: begin
          if (mul_done) begin
            issued   <= 1'b0;
            sum_g_xx <= whc_pkg::sat_add(sum_g_xx, ms_w);
            state    <= ST_W2;
          end
        end
        ST_W2: begin
          if (mul_done) begin
            issued   <= 1'b0;
            sum_g_xy <= whc_pkg::sat_add(sum_g_xy, ms_w);
            state    <= ST_W3;
          end
        end
        ST_W3: begin
          if (mul_done) begin
            issued   <= 1'b0;
            sum_g_yy <= whc_pkg::sat_add(sum_g_yy, ms_w);
            state    <= ST_W4;
          end
        end
        ST_W4: begin
          if (mul_done) begin
            issued  <= 1'b0;
            sum_m_x <= whc_pkg::sat_add(sum_m_x, ms_w);
            state   <= ST_W5;
          end
        end
        ST_W5: begin
          if (mul_done) begin
            issued  <= 1'b0;
            sum_m_y <= whc_pkg::sat_add(sum_m_y, ms_w);
            state   <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (!last) begin
            state <= ST_IDLE;
          end else if (bad_flag) begin
            o_x    <= 32'd0;
            o_y    <= 32'd0;
            o_ex   <= 31'd0;
            o_ey   <= 31'd0;
            o_cov  <= 32'd0;
            o_sing <= 1'b1;
            state  <= ST_OUT;
          end else begin
            p        <= sum_g_xx;
            q        <= sum_g_xy;
            r        <= sum_g_yy;
            fin_mode <= 1'b1;
            state    <= ST_INV;
          end
        end
        ST_RX1: begin
          if (mul_done) begin
            issued <= 1'b0;
            tmp    <= ms_f;
            state  <= ST_RX2;
          end
        end
        ST_RX2: begin
          if (mul_done) begin
            issued <= 1'b0;
            o_x    <= whc_pkg::sat32(whc_pkg::sat_add(tmp, ms_f));
            state  <= ST_RY1;
          end
        end
        ST_RY1: begin
          if (mul_done) begin
            issued <= 1'b0;
            tmp    <= ms_f;
            state  <= ST_RY2;
          end
        end
        ST_RY2: begin
          if (mul_done) begin
            issued <= 1'b0;
            o_y    <= whc_pkg::sat32(whc_pkg::sat_add(tmp, ms_f));
            state  <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (sq_done) begin
            issued <= 1'b0;
            o_ex   <= err_val;
            state  <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (sq_done) begin
            issued <= 1'b0;
            o_ey   <= err_val;
            o_cov  <= whc_pkg::sat32(gb);
            o_sing <= 1'b0;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          // run closes when the combined item is taken
          if (m_tready) begin
            sum_g_xx    <= 64'sd0;
            sum_g_xy    <= 64'sd0;
            sum_g_yy    <= 64'sd0;
            sum_m_x     <= 64'sd0;
            sum_m_y     <= 64'sd0;
            first_z     <= 32'd0;
            first_plane <= 16'd0;
            in_group    <= 1'b0;
            bad_flag    <= 1'b0;
            fin_mode    <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/whc_checker.sv @@
`include "assert_macros.svh"

module whc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [whc_pkg::OUT_W-1:0] m_tdata,
  input logic [0:0]                m_tuser,
  input logic                      m_tvalid,
  input logic                      m_tready
);

  `ASSERT_NEVER(a_no_take_with_result, clk, rst, m_tvalid && s_tready, "item taken while result pending")
  `ASSERT_CLK(a_busy_after_take, clk, rst, s_tvalid && s_tready |=> !s_tready && !m_tvalid, "not busy after item")
  `ASSERT_CLK(a_singular_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[63:0] == 64'd0 && m_tdata[189:96] == 94'd0, "singular result not zeroed")
  `ASSERT_CLK(a_result_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind weighted_hit_combiner_2d_unit whc_checker u_whc_checker (.*);

@@ tb/tb_weighted_hit_combiner_2d_unit.sv @@
module tb_weighted_hit_combiner_2d_unit;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [30:0]        ex, ey;
    logic signed [31:0] cov;
    logic [15:0]        w;
    logic               outl;
    logic [15:0]        plane;
    logic               last;
  } hit_t;

  typedef struct {
    logic [31:0] ex, ey, ez;
    logic [30:0] erx, ery;
    logic [31:0] cov;
    logic [15:0] plane;
    logic        sing;
  } combined_t;

  logic                       clk = 0;
  logic                       rst;
  logic [whc_pkg::IN_W-1:0]   s_tdata;
  logic [0:0]                 s_tuser;
  logic                       s_tlast;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [whc_pkg::OUT_W-1:0]  m_tdata;
  logic [0:0]                 m_tuser;
  logic                       m_tvalid;
  logic                       m_tready;

  // predictor state
  longint sg_xx, sg_xy, sg_yy, sm_x, sm_y;
  logic [31:0] grp_z;
  logic [15:0] grp_plane;
  bit grp_open, grp_bad;

  combined_t pending_results[$];
  int  err_count;
  bit  no_idle;
  int  cycles;

  weighted_hit_combiner_2d_unit dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic logic [63:0] mag(input longint a);
    logic [63:0] u;
    u = a;
    return (a < 0) ? (~u + 64'd1) : u;
  endfunction

  function automatic longint from_mag(input logic [127:0] m, input bit neg);
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? SMIN : SMAX;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint mul_shift(input longint a, input longint b, input int s);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    return from_mag(p >> s, (a < 0) != (b < 0));
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return longint'(s[63:0]);
  endfunction

  // trunc(n * 2^s / d) with d as magnitude and sign
  function automatic longint div_q(input longint n, input int s, input logic [127:0] dm,
                                   input bit dneg);
    return from_mag(({64'd0, mag(n)} << s) / dm, (n < 0) != dneg);
  endfunction

  // invert [[p,q],[q,r]]; returns 1 on a zero divisor
  function automatic bit invert2(input longint p, input longint q, input longint r,
                                 output longint a, output longint b, output longint c);
    logic [127:0] pr, qq, dm;
    bit dneg;
    a = 0; b = 0; c = 0;
    if (q == 0) begin
      if (p == 0 || r == 0) return 1;
      a = div_q(longint'(1) << FRAC, FRAC, {64'd0, mag(p)}, p < 0);
      c = div_q(longint'(1) << FRAC, FRAC, {64'd0, mag(r)}, r < 0);
      return 0;
    end
    pr = {64'd0, mag(p)} * {64'd0, mag(r)};
    qq = {64'd0, mag(q)} * {64'd0, mag(q)};
    if ((p < 0) != (r < 0)) begin
      dm = pr + qq; dneg = 1;
    end else if (pr >= qq) begin
      dm = pr - qq; dneg = 0;
    end else begin
      dm = qq - pr; dneg = 1;
    end
    if (dm == 0) return 1;
    a = div_q(r, 2 * FRAC, dm, dneg);
    b = div_q(q, 2 * FRAC, dm, !dneg);
    c = div_q(p, 2 * FRAC, dm, dneg);
    return 0;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [30:0] sigma_of(input longint e);
    logic [63:0] v, rt, bt;
    if (e <= 0) return '0;
    if (e >= (longint'(1) << (62 - FRAC))) return 31'h7FFF_FFFF;
    v = 64'(e) << FRAC;
    rt = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= rt + bt) begin
        v -= rt + bt;
        rt = (rt >> 1) + bt;
      end else begin
        rt >>= 1;
      end
      bt >>= 2;
    end
    return (rt > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rt[30:0];
  endfunction

  // folds one hit into the running sums; returns 1 when a combined hit is due
  function automatic bit combine_hit(input hit_t h, output combined_t r);
    longint x, y, vxx, vyy, g00, g01, g11, e00, e01, e11, tx, ty, w;
    bit sing;
    r = '{default: '0};
    x = longint'(h.x);
    y = longint'(h.y);
    w = longint'({48'd0, h.w});
    if (!grp_open) begin
      grp_z = h.z; grp_plane = h.plane; grp_open = 1;
    end
    if (!h.outl) begin
      vxx = longint'((64'(h.ex) * 64'(h.ex)) >> FRAC);
      vyy = longint'((64'(h.ey) * 64'(h.ey)) >> FRAC);
      if (invert2(vxx, longint'(h.cov), vyy, g00, g01, g11)) begin
        grp_bad = 1;
      end else begin
        tx = add_sat(mul_shift(g00, x, FRAC), mul_shift(g01, y, FRAC));
        ty = add_sat(mul_shift(g11, y, FRAC), mul_shift(g01, x, FRAC));
        sg_xx = add_sat(sg_xx, mul_shift(w, g00, whc_pkg::WEIGHT_FRAC));
        sg_xy = add_sat(sg_xy, mul_shift(w, g01, whc_pkg::WEIGHT_FRAC));
        sg_yy = add_sat(sg_yy, mul_shift(w, g11, whc_pkg::WEIGHT_FRAC));
        sm_x  = add_sat(sm_x, mul_shift(w, tx, whc_pkg::WEIGHT_FRAC));
        sm_y  = add_sat(sm_y, mul_shift(w, ty, whc_pkg::WEIGHT_FRAC));
      end
    end
    if (!h.last) return 0;
    sing = grp_bad || invert2(sg_xx, sg_xy, sg_yy, e00, e01, e11);
    if (!sing) begin
      r.ex  = clip32(add_sat(mul_shift(e00, sm_x, FRAC), mul_shift(e01, sm_y, FRAC)));
      r.ey  = clip32(add_sat(mul_shift(e11, sm_y, FRAC), mul_shift(e01, sm_x, FRAC)));
      r.erx = sigma_of(e00);
      r.ery = sigma_of(e11);
      r.cov = clip32(e01);
    end
    r.ez = grp_z;
    r.plane = grp_plane;
    r.sing = sing;
    sg_xx = 0; sg_xy = 0; sg_yy = 0; sm_x = 0; sm_y = 0;
    grp_z = 0; grp_plane = 0; grp_open = 0; grp_bad = 0;
    return 1;
  endfunction

  // ---------------- driving ----------------
  task automatic send_hit(input hit_t h);
    combined_t r;
    s_tdata  <= {2'd0, h.plane, h.w, h.cov, h.ey, h.ex, h.z, h.y, h.x};
    s_tuser  <= h.outl;
    s_tlast  <= h.last;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    if (combine_hit(h, r)) pending_results.push_back(r);
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic hit_t mk(input int x, input int y, input int z, input int ex,
                              input int ey, input int cov, input int w, input bit outl,
                              input int plane, input bit last);
    hit_t h;
    h.x = x; h.y = y; h.z = z; h.ex = 31'(ex); h.ey = 31'(ey); h.cov = cov;
    h.w = 16'(w); h.outl = outl; h.plane = 16'(plane); h.last = last;
    return h;
  endfunction

  // plausible hit: moderate sigmas, covariance inside the sigma product
  function automatic hit_t plausible_hit(input bit last);
    hit_t h;
    int lim;
    h.x = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    h.y = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    h.z = $urandom;
    h.ex = 31'($urandom_range(3000, 1500000));
    h.ey = 31'($urandom_range(3000, 1500000));
    lim = int'((64'(h.ex) * 64'(h.ey)) >> (FRAC + 1));
    h.cov = ($urandom_range(0, 99) < 30) ? 0 : $signed($urandom_range(0, 2 * lim)) - lim;
    h.w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    h.outl = ($urandom_range(0, 9) == 0);
    h.plane = 16'($urandom);
    h.last = last;
    return h;
  endfunction

  function automatic hit_t noise_hit(input bit last);
    hit_t h;
    h.x = $urandom; h.y = $urandom; h.z = $urandom;
    h.ex = 31'($urandom); h.ey = 31'($urandom); h.cov = $urandom;
    h.w = 16'($urandom); h.outl = 1'($urandom_range(0, 1)); h.plane = 16'($urandom);
    h.last = last;
    return h;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    send_hit(mk(32'h0001_8000, -32'sh0002_0000, 7, 32'h1_0000, 32'h1_0000, 0, 32768, 0, 3, 1));
    send_hit(mk(32'h0003_0000, 32'h0001_0000, 11, 32'h2_0000, 32'h1_8000, 32'h0_8000,
                20000, 0, 5, 0));
    send_hit(mk(-32'sh0001_0000, 32'h0000_4000, 12, 32'h1_0000, 32'h3_0000, -32'sh0_4000,
                32768, 0, 6, 1));
    // zero sigma: singular hit
    send_hit(mk(100, 200, 13, 0, 32'h1_0000, 0, 32768, 0, 7, 1));
    // zero determinant
    send_hit(mk(100, 200, 14, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32768, 0, 8, 1));
    // outlier first hit still gives z and plane
    send_hit(mk(999, 999, -5, 0, 0, 0, 32768, 1, 32'h0000_ABCD, 0));
    send_hit(mk(32'h0005_0000, 32'h0006_0000, 1, 32'h1_0000, 32'h1_0000, 0, 32768, 0, 2, 1));
    // every hit an outlier
    send_hit(mk(1, 2, 3, 32'h1_0000, 32'h1_0000, 0, 32768, 1, 9, 0));
    send_hit(mk(4, 5, 6, 32'h1_0000, 32'h1_0000, 0, 32768, 1, 10, 1));
    // field extremes
    send_hit(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h0000_FFFF, 0, 32'h0000_FFFF, 1));
    send_hit(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000,
                32'h0000_FFFF, 0, 0, 1));
    send_hit(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 256, 256, 0, 32768, 0, 1, 1));
    // zero weight leaves the sums empty
    send_hit(mk(32'h0001_0000, 32'h0001_0000, 2, 32'h1_0000, 32'h1_0000, 0, 0, 0, 4, 1));
    // negative determinant path: covariance larger than sigma product
    send_hit(mk(32'h0001_0000, 32'h0002_0000, 3, 32'h1_0000, 32'h0_8000, 32'h4_0000,
                32768, 0, 12, 0));
    send_hit(mk(32'h0002_0000, -32'sh0001_0000, 4, 32'h0_8000, 32'h1_0000, -32'sh3_0000,
                16384, 0, 13, 1));
  endtask

  task automatic test_random_groups(input int n_items, input bit quiet);
    int sent, len;
    no_idle = quiet;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) send_hit(plausible_hit(i == len - 1));
      sent += len;
    end
    no_idle = 0;
  endtask

  task automatic test_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 3) == 0) send_hit(plausible_hit($urandom_range(0, 2) == 0));
      else send_hit(noise_hit($urandom_range(0, 2) == 0));
    end
    // close any open group
    send_hit(plausible_hit(1));
  endtask

  // ---------------- result checking ----------------
  task automatic report(input string fld, input logic [31:0] exp_v, input logic [31:0] act_v);
    err_count++;
    $display("%0t: %s expected %h actual %h", $time, fld, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    combined_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: combined hit with none expected, actual %h", $time, m_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[31:0] !== e.ex) report("eff_x", e.ex, m_tdata[31:0]);
        if (m_tdata[63:32] !== e.ey) report("eff_y", e.ey, m_tdata[63:32]);
        if (m_tdata[95:64] !== e.ez) report("eff_z", e.ez, m_tdata[95:64]);
        if (m_tdata[126:96] !== e.erx) report("eff_err_x", e.erx, m_tdata[126:96]);
        if (m_tdata[157:127] !== e.ery) report("eff_err_y", e.ery, m_tdata[157:127]);
        if (m_tdata[189:158] !== e.cov) report("eff_cov_xy", e.cov, m_tdata[189:158]);
        if (m_tdata[205:190] !== e.plane) report("eff_plane", e.plane, m_tdata[205:190]);
        if (m_tuser[0] !== e.sing) report("singular", e.sing, m_tuser[0]);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 26);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_hit_combiner_2d_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1; s_tdata = '0; s_tuser = '0; s_tlast = 0; s_tvalid = 0; m_tready = 0;
    cycles = 0; err_count = 0; no_idle = 0;
    sg_xx = 0; sg_xy = 0; sg_yy = 0; sm_x = 0; sm_y = 0;
    grp_z = 0; grp_plane = 0; grp_open = 0; grp_bad = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random_groups(500, 0);
    test_random_groups(200, 1);
    test_random_groups(300, 0);
    test_noise(220);
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (err_count == 0) $display("weighted_hit_combiner_2d_unit: match");
    else $display("weighted_hit_combiner_2d_unit: mismatch");
    $finish;
  end

endmodule

@@ weighted_hit_combiner_2d_unit.f @@
+incdir+design
design/whc_pkg.sv
design/whc_mul.sv
design/whc_div.sv
design/whc_sqrt.sv
design/weighted_hit_combiner_2d_unit.sv
design/whc_checker.sv
tb/tb_weighted_hit_combiner_2d_unit.sv
